// ===== src/stbt_pkg.sv =====
// Package for the band tracker: widths, constants and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stbt_pkg;
    localparam int unsigned MAX_WINDOW_DEF = 1023;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULT = 1'd1;
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned BAND_W = 42;
    localparam int unsigned ACC_W = 48;
    localparam int unsigned DIV_W = 64;
    localparam int unsigned FRAC_EXTRA = 16;
    localparam logic [9:0] WINDOW_RESET = 10'd14;
    localparam logic [15:0] MULT_RESET = 16'd768;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_start;
        logic mul_lo;
        logic mul_hi;
        logic finish;
    } stbt_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } stbt_status_t;
endpackage
`default_nettype wire

// ===== src/supertrend_band_tracker_unit.sv =====
// Timing: a bar that needs no division passes S_PREP, S_DSTA and S_FIN before its result beat is
// valid; a bar that runs the 64-step serial divider also passes S_DIV, S_MLO and S_MHI.
// Throughput: one bar at a time; the next bar is taken the cycle after the result beat leaves.
// The divider for the seed mean and the average update sets the rate.
// Reset clears the series state, loads window 14 and multiplier 3.0, and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module supertrend_band_tracker_unit #(
    parameter int unsigned MAX_WINDOW = stbt_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [stbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [stbt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [stbt_pkg::PRICE_W-1:0]    bar_high,
    input  wire logic [stbt_pkg::PRICE_W-1:0]    bar_low,
    input  wire logic [stbt_pkg::PRICE_W-1:0]    bar_close,
    input  wire logic                            new_series,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [stbt_pkg::BAND_W-1:0]   trend_line,
    output logic                                 direction_up,
    output logic [stbt_pkg::PRICE_W-1:0]         range_average,
    output logic                                 ready_res
);
    import stbt_pkg::*;

    stbt_cmd_t cmd;
    stbt_status_t status;

    stbt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
    );

    stbt_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .bar_high(bar_high), .bar_low(bar_low),
        .bar_close(bar_close), .new_series(new_series), .cmd(cmd), .status(status),
        .trend_line(trend_line), .direction_up(direction_up),
        .range_average(range_average), .ready_res(ready_res)
    );

    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> !(in_valid && in_ready))
        else $error("Input beat taken while a result beat waits.");
    a_line_zero_warm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ready_res |-> trend_line == '0 && direction_up)
        else $error("Trend line set before the series is ready.");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({trend_line, direction_up, range_average, ready_res}))
        else $error("Result beat changed while waiting.");
endmodule
`default_nettype wire

// ===== src/stbt_ctrl.sv =====
// Controller state machine for the band tracker.
// Depends on stbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stbt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output stbt_pkg::stbt_cmd_t     cmd,
    input  wire stbt_pkg::stbt_status_t status
);
    import stbt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_DSTA = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_MLO  = 7'b0010000,
        S_MHI  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = S_DSTA;
            end
            S_DSTA:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/stbt_datapath.sv =====
// Datapath for the band tracker: series state, serial divider, band multiply and selection.
// Depends on stbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stbt_datapath #(
    parameter int unsigned MAX_WINDOW = stbt_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [stbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [stbt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [stbt_pkg::PRICE_W-1:0]  bar_high,
    input  wire logic [stbt_pkg::PRICE_W-1:0]  bar_low,
    input  wire logic [stbt_pkg::PRICE_W-1:0]  bar_close,
    input  wire logic                          new_series,
    input  wire stbt_pkg::stbt_cmd_t           cmd,
    output stbt_pkg::stbt_status_t             status,
    output logic signed [stbt_pkg::BAND_W-1:0] trend_line,
    output logic                               direction_up,
    output logic [stbt_pkg::PRICE_W-1:0]       range_average,
    output logic                               ready_res
);
    import stbt_pkg::*;

    localparam int unsigned CNT_W = 11;
    localparam logic [10:0] P_CAP = (MAX_WINDOW > 1023) ? 11'd1023 : 11'(MAX_WINDOW);
    localparam logic signed [BAND_W+1:0] BMAX = {3'b000, {(BAND_W-1){1'b1}}};
    localparam logic signed [BAND_W+1:0] BMIN = {3'b111, {(BAND_W-1){1'b0}}};

    logic [9:0] win_reg;
    logic [15:0] mult_reg;
    logic clear_pend_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [PRICE_W-1:0] last_close_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [BAND_W-1:0] fup_reg, flo_reg;
    logic trend_reg;

    logic [PRICE_W-1:0] hi_reg, lo_reg, cl_reg;
    logic [CNT_W-1:0] n_reg;
    logic [32:0] tr_reg;
    logic [10:0] p_reg;
    logic have_reg, ema_reg;

    logic [DIV_W-1:0] num_reg, quo_reg;
    logic [DIV_W:0] rem_reg;
    logic [10:0] den_reg;
    logic [6:0] dcnt_reg;
    logic busy_reg;
    logic [63:0] prod_reg;

    logic signed [BAND_W-1:0] line_reg;
    logic dir_reg;
    logic [PRICE_W-1:0] avg_out_reg;
    logic ready_reg;

    logic [10:0] p_eff;
    logic [CNT_W-1:0] seen_eff;
    logic [32:0] d_hl, d_hc, d_lc, tr_now;
    logic signed [33:0] shc, slc;

    always_comb
    begin
        p_eff = {1'b0, win_reg};
        if (p_eff == 11'd0)
        begin
            p_eff = 11'd1;
        end
        if (p_eff > P_CAP)
        begin
            p_eff = P_CAP;
        end
        seen_eff = (new_series || clear_pend_reg) ? '0 : seen_reg;
        d_hl = {1'b0, bar_high} - {1'b0, bar_low};
        shc = $signed({2'b00, bar_high}) - $signed({2'b00, last_close_reg});
        slc = $signed({2'b00, bar_low}) - $signed({2'b00, last_close_reg});
        d_hc = shc[33] ? 33'(-shc) : shc[32:0];
        d_lc = slc[33] ? 33'(-slc) : slc[32:0];
        if (seen_eff == '0)
        begin
            tr_now = d_hl[32] ? 33'd0 : d_hl;
        end
        else
        begin
            tr_now = d_hl[32] ? 33'd0 : d_hl;
            if (d_hc > tr_now) tr_now = d_hc;
            if (d_lc > tr_now) tr_now = d_lc;
        end
    end

    assign status = '{need_div: have_reg, div_done: busy_reg && (dcnt_reg == 7'd0)};

    logic [DIV_W:0] rem_sh;
    logic [DIV_W-1:0] seed_num, ema_num;
    logic [ACC_W-1:0] acc_sum;
    assign rem_sh = {rem_reg[DIV_W-1:0], num_reg[DIV_W-1]};
    assign acc_sum = acc_reg + ACC_W'(tr_reg);
    assign seed_num = (DIV_W'(acc_sum) << FRAC_EXTRA) + DIV_W'(p_reg >> 1);
    assign ema_num = DIV_W'(acc_reg) * DIV_W'(p_reg - 11'd1)
                   + (DIV_W'(tr_reg) << (FRAC_EXTRA + 1)) + DIV_W'((p_reg + 11'd1) >> 1);

    logic signed [BAND_W+1:0] mid, off, ub_s, lb_s;
    logic signed [BAND_W-1:0] ub, lb;
    logic t_next;
    always_comb
    begin
        mid = $signed((BAND_W+2)'(({1'b0, hi_reg} + {1'b0, lo_reg}) >> 1));
        off = $signed((BAND_W+2)'((prod_reg + 64'h80_0000) >> 24));
        ub_s = mid + off;
        lb_s = mid - off;
        ub = (ub_s > BMAX) ? BMAX[BAND_W-1:0] : ub_s[BAND_W-1:0];
        lb = (lb_s < BMIN) ? BMIN[BAND_W-1:0] : lb_s[BAND_W-1:0];
        t_next = trend_reg;
        if (ema_reg)
        begin
            if ($signed({10'd0, last_close_reg}) > fup_reg && flo_reg > lb) lb = flo_reg;
            if ($signed({10'd0, last_close_reg}) < flo_reg && fup_reg < ub) ub = fup_reg;
            if ($signed({10'd0, cl_reg}) > ub) t_next = 1'b1;
            else if ($signed({10'd0, cl_reg}) < lb) t_next = 1'b0;
        end
    end

    logic [ACC_W:0] avg_r;
    assign avg_r = {1'b0, acc_reg} + (ACC_W+1)'(1 << (FRAC_EXTRA - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WINDOW_RESET;
            mult_reg <= MULT_RESET;
            clear_pend_reg <= 1'b0;
            seen_reg <= '0;
            last_close_reg <= '0;
            acc_reg <= '0;
            fup_reg <= '0;
            flo_reg <= '0;
            trend_reg <= 1'b1;
            busy_reg <= 1'b0;
            hi_reg <= '0;
            lo_reg <= '0;
            cl_reg <= '0;
            tr_reg <= '0;
            n_reg <= '0;
            p_reg <= '0;
            have_reg <= 1'b0;
            ema_reg <= 1'b0;
            num_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
            dcnt_reg <= '0;
            prod_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW:
                    begin
                        win_reg <= cfg_data[9:0];
                        clear_pend_reg <= 1'b1;
                    end
                    REG_MULT: mult_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                hi_reg <= bar_high;
                lo_reg <= bar_low;
                cl_reg <= bar_close;
                tr_reg <= tr_now;
                n_reg <= seen_eff;
                p_reg <= p_eff;
                clear_pend_reg <= 1'b0;
                if (new_series || clear_pend_reg)
                begin
                    acc_reg <= '0;
                    fup_reg <= '0;
                    flo_reg <= '0;
                    trend_reg <= 1'b1;
                end
            end
            if (cmd.prep)
            begin
                ema_reg <= (n_reg >= p_reg);
                have_reg <= (n_reg >= p_reg - 11'd1);
                if (n_reg >= p_reg)
                begin
                    num_reg <= ema_num;
                    den_reg <= p_reg + 11'd1;
                end
                else
                begin
                    num_reg <= seed_num;
                    den_reg <= p_reg;
                    acc_reg <= acc_sum;
                end
            end
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                dcnt_reg <= 7'(DIV_W);
                rem_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (dcnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    acc_reg <= quo_reg[ACC_W-1:0];
                end
                else
                begin
                    dcnt_reg <= dcnt_reg - 7'd1;
                    num_reg <= num_reg << 1;
                    if (rem_sh >= (DIV_W+1)'(den_reg))
                    begin
                        rem_reg <= rem_sh - (DIV_W+1)'(den_reg);
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                end
            end
            if (cmd.mul_lo)
            begin
                prod_reg <= 64'(mult_reg) * 64'(acc_reg[23:0]);
            end
            if (cmd.mul_hi)
            begin
                prod_reg <= prod_reg + ((64'(mult_reg) * 64'(acc_reg[ACC_W-1:24])) << 24);
            end
            if (cmd.finish)
            begin
                last_close_reg <= cl_reg;
                seen_reg <= (n_reg + 11'd1 > p_reg + 11'd1) ? p_reg + 11'd1 : n_reg + 11'd1;
                if (have_reg)
                begin
                    fup_reg <= ub;
                    flo_reg <= lb;
                    trend_reg <= t_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            line_reg <= (have_reg && ema_reg) ? (t_next ? lb : ub) : '0;
            dir_reg <= have_reg ? t_next : trend_reg;
            ready_reg <= have_reg && ema_reg;
            avg_out_reg <= !have_reg ? '0
                : (|avg_r[ACC_W:FRAC_EXTRA+PRICE_W]) ? '1 : avg_r[FRAC_EXTRA+PRICE_W-1:FRAC_EXTRA];
        end
    end

    assign trend_line = line_reg;
    assign direction_up = dir_reg;
    assign range_average = avg_out_reg;
    assign ready_res = ready_reg;
endmodule
`default_nettype wire
